[src/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, sizes and the sequencer microprogram of the page walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // Field widths
    localparam int VA_W     = 48;
    localparam int PA_W     = 48;
    localparam int ENTRY_W  = 64;
    localparam int FRAME_W  = 36;
    localparam int IDX_W    = 9;
    localparam int OFF_W    = 12;
    localparam int LVL_W    = 2;

    // Entry store: one word per 8-byte table entry
    localparam int STORE_WORDS = 4096;
    localparam int STORE_AW    = $clog2(STORE_WORDS);
    localparam int WORD_W      = PA_W - 3;

    // Microprogram counter
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_IDLE    = 3'd0;
    localparam pc_t PC_RD_ROOT = 3'd1;
    localparam pc_t PC_CHECK   = 3'd2;
    localparam pc_t PC_EMIT    = 3'd3;
    localparam pc_t PC_LD_RD   = 3'd4;
    localparam pc_t PC_LD_WR   = 3'd5;

    // Next-step selection of a control word
    typedef enum logic [2:0] {
        COND_SEQ,       // go to the following step
        COND_GOTO,      // go to target
        COND_WAIT_IN,   // hold until a transfer; load -> target, translate -> next
        COND_LOOP,      // target while more levels remain, else next
        COND_WAIT_OUT   // hold while result register is busy, then target
    } cond_t;

    // One control word
    typedef struct packed {
        logic  take;     // input channel open
        logic  rd_walk;  // read entry at current base and level index
        logic  chk;      // check entry, read next level
        logic  rd_load;  // read entry at load address
        logic  wr_load;  // write load entry if still unwritten
        logic  emit;     // move result into the output register
        cond_t cond;
        pc_t   target;
    } ctl_t;

    // Status seen by the sequencer
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic is_load;    // accepted item is a load
        logic walk_more;  // entry good and levels remain
        logic out_busy;   // result register full and not drained
    } seq_stat_t;

    // Microprogram ROM
    function automatic ctl_t ucode_rom(input pc_t pc);
        ctl_t w;
        w = '{take: 1'b0, rd_walk: 1'b0, chk: 1'b0, rd_load: 1'b0, wr_load: 1'b0,
              emit: 1'b0, cond: COND_GOTO, target: PC_IDLE};
        case (pc)
            PC_IDLE:
            begin
                w.take   = 1'b1;
                w.cond   = COND_WAIT_IN;
                w.target = PC_LD_RD;
            end
            PC_RD_ROOT:
            begin
                w.rd_walk = 1'b1;
                w.cond    = COND_SEQ;
            end
            PC_CHECK:
            begin
                w.chk    = 1'b1;
                w.cond   = COND_LOOP;
                w.target = PC_CHECK;
            end
            PC_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_WAIT_OUT;
                w.target = PC_IDLE;
            end
            PC_LD_RD:
            begin
                w.rd_load = 1'b1;
                w.cond    = COND_SEQ;
            end
            PC_LD_WR:
            begin
                w.wr_load = 1'b1;
                w.cond    = COND_GOTO;
                w.target  = PC_IDLE;
            end
            default:
            begin
                w.cond   = COND_GOTO;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    // Table index of a logical address for one walk level
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] la,
                                                      input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = la[47:39];
            2'd1:    idx = la[38:30];
            2'd2:    idx = la[29:21];
            default: idx = la[20:12];
        endcase
        return idx;
    endfunction

endpackage

[src/ptw_if.sv]
// ----------------------------------------------------------------------------
// Page walker channels
// Valid/ready channels for items, results and the root frame register.
// ----------------------------------------------------------------------------

// Input items: loads and translations
interface ptw_item_if;
    import ptw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [PA_W-1:0]      entry_address;
    logic [ENTRY_W-1:0]   entry_value;
    logic [VA_W-1:0]      lin_addr;

    modport source (output valid, func, entry_address, entry_value, lin_addr,
                    input ready);
    modport sink   (input valid, func, entry_address, entry_value, lin_addr,
                    output ready);
endinterface

// Translation results
interface ptw_result_if;
    import ptw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 fault;
    logic [PA_W-1:0]      physical_address;

    modport source (output valid, fault, physical_address, input ready);
    modport sink   (input valid, fault, physical_address, output ready);
endinterface

// Root frame register writes
interface ptw_cfg_if;
    import ptw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [FRAME_W-1:0]   root_frame;

    modport source (output valid, root_frame, input ready);
    modport sink   (input valid, root_frame, output ready);
endinterface

[src/ptw_seq.sv]
// ----------------------------------------------------------------------------
// ptw_seq
// Microprogram sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
module ptw_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  ptw_pkg::seq_stat_t stat,
    output ptw_pkg::ctl_t      ctl
);
    import ptw_pkg::*;

    pc_t pc_reg;
    pc_t pc_next;
    pc_t pc_inc;

    // Current control word
    assign ctl    = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + pc_t'(1);

    // Next step
    always_comb
    begin
        pc_next = pc_reg;
        case (ctl.cond)
            COND_SEQ:      pc_next = pc_inc;
            COND_GOTO:     pc_next = ctl.target;
            COND_WAIT_IN:
            begin
                if (stat.accept)
                begin
                    pc_next = stat.is_load ? ctl.target : pc_inc;
                end
            end
            COND_LOOP:     pc_next = stat.walk_more ? ctl.target : pc_inc;
            COND_WAIT_OUT: pc_next = stat.out_busy ? pc_reg : ctl.target;
            default:       pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[src/four_level_page_table_walker_top.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Four-level page walk over a store of 64-bit table entries.
// ----------------------------------------------------------------------------
// Use:
//   item   : load (func 0) writes an entry at an 8-byte aligned physical
//            address, first write wins; translate (func 1) walks four levels
//            from the root frame and returns one result.
//   result : fault flag and physical address (zero on fault).
//   cfg    : root frame number; write only while the block is idle.
// Flow:
//   One item at a time. A load reads its entry and then writes it, before
//   the next ready. A translation reads one entry per level, checking one
//   level while reading the next, then registers the result; a fault at an
//   earlier level ends the walk early.
// Reset:
//   After reset a clearing pass marks all 4096 store words unwritten, one
//   word per cycle; item.ready stays low until the pass ends. cfg writes
//   are taken throughout.
// Stall:
//   A held result does not block loads or the next translation; that
//   translation waits at its output step, item.ready low, until it drains.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top
(
    input  logic          clk,
    input  logic          rst_n,
    ptw_item_if.sink      item,
    ptw_result_if.source  result,
    ptw_cfg_if.sink       cfg
);
    import ptw_pkg::*;

    ctl_t      ctl;
    seq_stat_t stat;

    // Clearing pass
    logic                clr_active_reg;
    logic                clr_active_next;
    logic [STORE_AW-1:0] clr_cnt_reg;
    logic [STORE_AW-1:0] clr_cnt_next;

    // Configuration
    logic [FRAME_W-1:0]  root_frame_reg;

    // Item holding registers
    logic [VA_W-1:0]     la_reg;
    logic [PA_W-1:0]     ld_addr_reg;
    logic [ENTRY_W-1:0]  ld_val_reg;

    // Walk state
    logic [FRAME_W-1:0]  base_frame_reg;
    logic [LVL_W-1:0]    level_reg;
    logic                fault_reg;

    // Entry store: valid bit on top of the entry
    logic [ENTRY_W:0]    store_mem [STORE_WORDS];
    logic [ENTRY_W:0]    rd_q_reg;
    logic                rd_oor_reg;
    logic                rd_oor_next;
    logic [WORD_W-1:0]   rd_word;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [ENTRY_W:0]    wr_data;

    // Result register
    logic                res_valid_reg;
    logic                res_fault_reg;
    logic [PA_W-1:0]     res_pa_reg;

    logic                accept;
    logic                entry_ok;
    logic                emit_fire;

    // Sequencer
    ptw_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Handshakes
    assign item.ready = ctl.take && !clr_active_reg;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid            = res_valid_reg;
    assign result.fault            = res_fault_reg;
    assign result.physical_address = res_pa_reg;

    // Entry check of the word read last cycle
    assign entry_ok  = !rd_oor_reg && rd_q_reg[ENTRY_W] && rd_q_reg[0];
    assign emit_fire = ctl.emit && !stat.out_busy;

    assign stat.accept    = accept;
    assign stat.is_load   = !item.func;
    assign stat.walk_more = entry_ok && (level_reg != LVL_W'(3));
    assign stat.out_busy  = res_valid_reg && !result.ready;

    // Read address: root level, next level from read data, or load address
    always_comb
    begin
        rd_word = '0;
        if (ctl.rd_walk)
        begin
            rd_word = {base_frame_reg, level_index(la_reg, level_reg)};
        end
        else if (ctl.chk)
        begin
            rd_word = {rd_q_reg[PA_W-1:OFF_W], level_index(la_reg, level_reg + LVL_W'(1))};
        end
        else if (ctl.rd_load)
        begin
            rd_word = ld_addr_reg[PA_W-1:3];
        end
        rd_oor_next = (rd_word >= WORD_W'(STORE_WORDS))
                   || (ctl.rd_load && (ld_addr_reg[2:0] != 3'd0));
    end

    // Write port: clearing pass or first load of a word
    always_comb
    begin
        wr_en   = clr_active_reg || (ctl.wr_load && !rd_oor_reg && !rd_q_reg[ENTRY_W]);
        wr_addr = clr_active_reg ? clr_cnt_reg : ld_addr_reg[3 +: STORE_AW];
        wr_data = clr_active_reg ? '0 : {1'b1, ld_val_reg};
    end

    // Clear pass counter
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + STORE_AW'(1);
            if (clr_cnt_reg == STORE_AW'(STORE_WORDS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // Entry store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= store_mem[rd_word[STORE_AW-1:0]];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            root_frame_reg <= '0;
            rd_oor_reg     <= 1'b0;
            level_reg      <= '0;
            fault_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            rd_oor_reg     <= rd_oor_next;
            if (cfg.valid && cfg.ready)
            begin
                root_frame_reg <= cfg.root_frame;
            end
            if (accept)
            begin
                level_reg <= '0;
                fault_reg <= 1'b0;
            end
            else if (ctl.chk)
            begin
                if (!entry_ok)
                begin
                    fault_reg <= 1'b1;
                end
                else if (level_reg != LVL_W'(3))
                begin
                    level_reg <= level_reg + LVL_W'(1);
                end
            end
            if (emit_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            la_reg         <= item.lin_addr;
            ld_addr_reg    <= item.entry_address;
            ld_val_reg     <= item.entry_value;
            base_frame_reg <= root_frame_reg;
        end
        else if (ctl.chk && entry_ok && (level_reg == LVL_W'(3)))
        begin
            base_frame_reg <= rd_q_reg[PA_W-1:OFF_W];
        end
        if (emit_fire)
        begin
            res_fault_reg <= fault_reg;
            res_pa_reg    <= fault_reg ? '0 : {base_frame_reg, la_reg[OFF_W-1:0]};
        end
    end

`ifndef SYNTHESIS
    // No item enters while the store is being cleared
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !item.ready)
        else $error("item accepted during clearing pass");

    // A faulted result carries a zero address
    a_fault_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_fault_reg) |-> (res_pa_reg == '0))
        else $error("faulted result with nonzero address");

    // Every walk starts at level zero with no fault
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.func) |=> (level_reg == '0 && !fault_reg))
        else $error("walk did not start clean");
`endif

endmodule

[tb/four_level_page_table_walker_top_tb.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top_tb
// Self-checking bench for the four-level page walker. Table entries are loaded
// and logical addresses translated under several root frames. A clocked driver
// feeds the item channel from a queue and predicts each walk as it transfers.
// A clocked monitor compares every result with the oldest prediction. Both
// sides idle at random; one long receiver stall fills up the block.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptw_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TABLE_ENTRIES  = 512;
    localparam int STORE_FRAMES   = STORE_WORDS / TABLE_ENTRIES;
    localparam int TOP_SHIFT      = 39;
    localparam int LEVELS         = 4;
    localparam int MAX_GAP        = 6;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 190;
    localparam int FAULT_ITEMS    = 40;
    localparam int HOLD_PHASE     = 2;
    localparam int QUIET_PHASE    = 4;
    localparam int TIMEOUT_CYCLES = 250_000;
    localparam logic [FRAME_W-1:0] ROOT_MAX = '1;

    typedef enum logic {FN_LOAD = 1'b0, FN_WALK = 1'b1} walk_fn_t;

    // One queued item; a drain entry makes the sender wait for all results
    typedef struct {
        bit                  drain;
        walk_fn_t            fn;
        logic [PA_W-1:0]     ent_addr;
        logic [ENTRY_W-1:0]  ent_val;
        logic [VA_W-1:0]     la;
        int unsigned         gap;
    } walk_req_t;

    typedef struct packed {
        logic              fault;
        logic [PA_W-1:0]   pa;
    } xlate_t;

    logic clk = 1'b0;
    logic rst_n;

    ptw_item_if   item_ch ();
    ptw_result_if res_ch ();
    ptw_cfg_if    cfg_ch ();

    four_level_page_table_walker_top u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predicted state of the block
    logic [ENTRY_W-1:0] pte_mem [STORE_WORDS];
    bit                 pte_set [STORE_WORDS];
    logic [FRAME_W-1:0] root_q = '0;
    xlate_t             xlate_expected [$];

    // Stimulus side
    walk_req_t          pending [$];
    logic [ENTRY_W-1:0] plan_pte [int];
    logic [FRAME_W-1:0] plan_root = '0;
    int                 plan_made;
    bit                 tx_quiet;
    bit                 rx_quiet;
    bit                 hold_go;
    logic               hold_off;

    walk_req_t   tx_cur;
    walk_req_t   tx_head;
    bit          tx_offer;
    int unsigned tx_idle;
    int unsigned rx_wait;
    xlate_t      rx_exp;

    int err_cnt;
    int n_loads;
    int n_walks;
    int n_faults;
    int n_roots;

    function automatic logic [PA_W-1:0] rand48();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[PA_W-1:0];
    endfunction

    function automatic logic [ENTRY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [IDX_W-1:0] la_index(input logic [VA_W-1:0] la, input int lvl);
        logic [VA_W-1:0] sh;
        sh = la >> (TOP_SHIFT - IDX_W * lvl);
        return sh[IDX_W-1:0];
    endfunction

    // Applies one transferred item to the predicted state
    function automatic void walker_predict(input walk_req_t r);
        logic [PA_W-1:0]   base;
        logic [PA_W-1:0]   ea;
        logic [PA_W-4:0]   wd;
        xlate_t            res;
        if (r.fn == FN_LOAD)
        begin
            wd = r.ent_addr[PA_W-1:3];
            // unaligned, out-of-range and repeated loads leave the store alone
            if (r.ent_addr[2:0] == 3'b000 && wd < STORE_WORDS
                && !pte_set[wd[STORE_AW-1:0]])
            begin
                pte_mem[wd[STORE_AW-1:0]] = r.ent_val;
                pte_set[wd[STORE_AW-1:0]] = 1'b1;
                n_loads++;
            end
            return;
        end
        base = {root_q, {OFF_W{1'b0}}};
        res.fault = 1'b0;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            ea = base + {la_index(r.la, lvl), 3'b000};
            wd = ea[PA_W-1:3];
            if (wd >= STORE_WORDS || !pte_set[wd[STORE_AW-1:0]]
                || !pte_mem[wd[STORE_AW-1:0]][0])
            begin
                res.fault = 1'b1;
                break;
            end
            base = {pte_mem[wd[STORE_AW-1:0]][PA_W-1:OFF_W], {OFF_W{1'b0}}};
        end
        res.pa = res.fault ? '0 : base + r.la[OFF_W-1:0];
        xlate_expected.push_back(res);
        n_walks++;
        if (res.fault)
            n_faults++;
    endfunction

    function automatic int unsigned pick_gap();
        return tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void queue_load(input logic [PA_W-1:0] addr,
                                       input logic [ENTRY_W-1:0] val);
        walk_req_t r;
        int        w;
        r.drain    = 1'b0;
        r.fn       = FN_LOAD;
        r.ent_addr = addr;
        r.ent_val  = val;
        r.la       = rand48();
        r.gap      = pick_gap();
        pending.push_back(r);
        if (addr[2:0] == 3'b000 && addr[PA_W-1:3] < STORE_WORDS)
        begin
            w = int'(addr[PA_W-1:3]);
            if (!plan_pte.exists(w))
            begin
                plan_pte[w] = val;
                plan_made++;
            end
        end
    endfunction

    function automatic void queue_walk(input logic [VA_W-1:0] la);
        walk_req_t r;
        r.drain    = 1'b0;
        r.fn       = FN_WALK;
        r.ent_addr = rand48();
        r.ent_val  = rand64();
        r.la       = la;
        r.gap      = pick_gap();
        pending.push_back(r);
        plan_made++;
    endfunction

    function automatic void queue_pause();
        walk_req_t r;
        r.drain    = 1'b1;
        r.fn       = FN_LOAD;
        r.ent_addr = '0;
        r.ent_val  = '0;
        r.la       = '0;
        r.gap      = 0;
        pending.push_back(r);
    endfunction

    // Random entry; inner levels mostly point back into the store
    function automatic logic [ENTRY_W-1:0] rand_pte(input bit leaf);
        logic [ENTRY_W-1:0] v;
        logic [ENTRY_W-1:0] f;
        logic [FRAME_W-1:0] fr;
        v  = rand64();
        f  = rand64();
        fr = f[FRAME_W-1:0];
        if ((!leaf && $urandom_range(0, 15) != 0) || (leaf && $urandom_range(0, 3) == 0))
            fr = FRAME_W'($urandom_range(0, STORE_FRAMES - 1));
        v[PA_W-1:OFF_W] = fr;
        v[0] = ($urandom_range(0, 15) != 0);
        return v;
    endfunction

    // Loads missing entries along the path of la, bar the odd hole, then translates it
    function automatic void plan_walk(input logic [VA_W-1:0] la);
        logic [PA_W-1:0]    base;
        logic [ENTRY_W-1:0] v;
        int                 w;
        base = {plan_root, {OFF_W{1'b0}}};
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            if (base[PA_W-1:OFF_W] >= STORE_FRAMES)
                break;
            w = int'(base[PA_W-1:OFF_W]) * TABLE_ENTRIES + int'(la_index(la, lvl));
            if (!plan_pte.exists(w))
            begin
                // leave the odd hole so unwritten entries still show up
                if ($urandom_range(0, 19) == 0)
                    break;
                queue_load(PA_W'(w * 8), rand_pte(lvl == LEVELS - 1));
            end
            v = plan_pte[w];
            if (!v[0])
                break;
            base = {v[PA_W-1:OFF_W], {OFF_W{1'b0}}};
        end
        queue_walk(la);
    endfunction

    function automatic void plan_noise_load();
        logic [PA_W-1:0] a;
        logic [PA_W-4:0] wd;
        wd = WORD_W'($urandom_range(0, STORE_WORDS - 1));
        case ($urandom_range(0, 3))
            0: a = rand48();
            1: a = {wd, 3'b000};
            2: a = {wd, 3'b000} | PA_W'($urandom_range(1, 7));
            default:
            begin
                wd = WORD_W'($urandom_range(STORE_WORDS, 2 * STORE_WORDS));
                a  = {wd, 3'b000};
            end
        endcase
        queue_load(a, rand64());
    endfunction

    function automatic void plan_phase(input int target);
        logic [VA_W-1:0] la;
        plan_made = 0;
        while (plan_made < target)
        begin
            case ($urandom_range(0, 9))
                0: plan_noise_load();
                1: queue_walk(rand48());
                default:
                begin
                    la = rand48();
                    plan_walk(la);
                    // neighbors on the same path
                    repeat ($urandom_range(0, 2))
                    begin
                        la[OFF_W-1:0] = OFF_W'($urandom);
                        if ($urandom_range(0, 1) == 1)
                            la[OFF_W+IDX_W-1:OFF_W] = IDX_W'($urandom);
                        plan_walk(la);
                    end
                end
            endcase
            if ($urandom_range(0, 59) == 0)
                queue_pause();
        end
    endfunction

    // Edge cases of the store and the walk, with root frame 0
    function automatic void plan_directed();
        queue_walk(48'h0000_0000_0000);                            // empty store
        queue_load(48'h0000_0000_0000, 64'hFFFF_0000_0000_0FFF);   // zero frame
        queue_walk(48'h0000_0000_0ABC);
        queue_load(48'h0000_0000_0000, 64'h0000_0000_0000_0000);   // repeated load
        queue_walk(48'h0000_0000_0FFF);
        queue_load(48'h0000_0000_000B, 64'h0000_0000_0000_1001);   // unaligned
        queue_walk(48'h0000_0000_1000);
        queue_load(48'h0000_0000_8000, 64'h0000_0000_0000_1001);   // past the store
        queue_load(48'hFFFF_FFFF_FFF8, 64'h0000_0000_0000_1001);
        queue_load(48'hFFFF_FFFF_FFFF, 64'h0000_0000_0000_1001);
        queue_load(48'h0000_0000_0010, 64'h0000_0000_0000_5000);   // not present
        queue_walk(48'h0000_0000_2000);
        queue_load(48'h0000_0000_0018, 64'h0000_FFFF_FFFF_F001);   // top frame
        queue_walk(48'h0000_0000_3FFF);
        queue_load(48'h0000_0000_0020, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_walk(48'h0000_0000_4123);
        queue_load(48'h0000_0000_0030, 64'h0000_0000_0000_8001);   // frame past store
        queue_walk(48'h0000_00C0_0000);
        queue_walk(48'hFFFF_FFFF_FFFF);
        queue_load(48'h0000_0000_0FF8, 64'h0000_0000_0000_0001);
        queue_walk(48'hFFFF_FFFF_FFFF);
        queue_load(48'h0000_0000_7FF8, 64'h0000_0000_0000_7001);   // last word
        queue_walk(48'h0000_0000_0000);
    endfunction

    // Item driver: offers queued items after their gap, predicts on transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid         <= 1'b0;
            item_ch.func          <= FN_LOAD;
            item_ch.entry_address <= '0;
            item_ch.entry_value   <= '0;
            item_ch.lin_addr      <= '0;
            tx_offer = 1'b0;
            tx_idle  = 0;
        end
        else
        begin
            if (tx_offer && item_ch.ready)
            begin
                walker_predict(tx_cur);
                tx_offer = 1'b0;
                tx_idle  = 0;
            end
            else if (!tx_offer)
                tx_idle++;
            if (!tx_offer && pending.size() > 0)
            begin
                tx_head = pending[0];
                if (tx_head.drain)
                begin
                    if (xlate_expected.size() == 0)
                        void'(pending.pop_front());
                end
                else if (tx_idle >= tx_head.gap)
                begin
                    tx_cur   = pending.pop_front();
                    tx_offer = 1'b1;
                    item_ch.func          <= tx_cur.fn;
                    item_ch.entry_address <= tx_cur.ent_addr;
                    item_ch.entry_value   <= tx_cur.ent_val;
                    item_ch.lin_addr      <= tx_cur.la;
                end
            end
            item_ch.valid <= tx_offer;
        end
    end

    // Result monitor: checks each transfer, then draws the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (xlate_expected.size() == 0)
                begin
                    $error("unexpected result: fault=%0b physical_address=%h",
                           res_ch.fault, res_ch.physical_address);
                    err_cnt++;
                end
                else
                begin
                    rx_exp = xlate_expected.pop_front();
                    if (res_ch.fault !== rx_exp.fault)
                    begin
                        $error("fault: expected %0b, actual %0b", rx_exp.fault, res_ch.fault);
                        err_cnt++;
                    end
                    if (res_ch.physical_address !== rx_exp.pa)
                    begin
                        $error("physical_address: expected %h, actual %h",
                               rx_exp.pa, res_ch.physical_address);
                        err_cnt++;
                    end
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            else if (res_ch.valid && rx_wait > 0)
                rx_wait--;
            res_ch.ready <= (rx_wait == 0) && !hold_off;
        end
    end

    // Long receiver stall, counted here while the sender keeps going
    initial
    begin
        hold_off = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d items queued, %0d results outstanding",
                 pending.size(), xlate_expected.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic write_root(input logic [FRAME_W-1:0] r);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.root_frame <= r;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        root_q    = r;
        plan_root = r;
        n_roots++;
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until the block has nothing left in flight
    task automatic settle();
        while (pending.size() != 0 || tx_offer || xlate_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        logic [FRAME_W-1:0] roots [NUM_PHASES];
        logic [ENTRY_W-1:0] t;

        cfg_ch.valid      = 1'b0;
        cfg_ch.root_frame = '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        hold_go  = 1'b0;
        err_cnt  = 0;

        t = rand64();
        roots = '{'0, STORE_FRAMES - 1, 3, ROOT_MAX, '0, STORE_FRAMES, 5,
                  $urandom_range(0, STORE_FRAMES - 1), t[FRAME_W-1:0], 1, 6, 2};

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_root(roots[0]);
        plan_directed();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                settle();
                write_root(roots[ph]);
            end
            tx_quiet = (ph == QUIET_PHASE) || (ph == HOLD_PHASE);
            rx_quiet = (ph == QUIET_PHASE);
            if (ph == HOLD_PHASE)
                hold_go = 1'b1;
            plan_phase(roots[ph] < STORE_FRAMES ? PHASE_ITEMS : FAULT_ITEMS);
            queue_pause();
        end
        settle();

        $display("Covered %0d stored entries and %0d translations (%0d faulted)",
                 n_loads, n_walks, n_faults);
        $display("over %0d root frame settings, including a long result stall", n_roots);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
